/* hdl/efvm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package efvm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COUNT_BITS     = 24;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int EVENT_BITS     = 32;
  localparam int SUM_BITS       = 40;
  localparam int MAG_BITS       = 28;
  localparam int HARM_BITS      = 4;
  localparam int CORDIC_STEPS   = 28;
  localparam int CORDIC_FRAC    = 30;
  localparam int ROT_BITS       = 33;
  localparam int Z_BITS         = 32;
  localparam int STEP_BITS      = 5;
  localparam int TRIG_BITS      = TRIG_FRAC_BITS + 2;
  localparam int HALF_BITS      = SUM_BITS / 2;
  localparam int SQ_BITS        = 2 * SUM_BITS;
  localparam int NORM_SHIFT     = 32 - 2 * TRIG_FRAC_BITS;
  localparam int NUM_BITS       = SQ_BITS + NORM_SHIFT;
  localparam int RAD_BITS       = 2 * MAG_BITS;
  localparam int SREM_BITS      = MAG_BITS + 2;
  localparam int CNT_BITS       = 7;

  localparam logic [HARM_BITS-1:0]  HARM_RESET = HARM_BITS'(2);
  localparam logic [EVENT_BITS-1:0] EVENT_RESET = EVENT_BITS'(1);
  localparam logic signed [ROT_BITS-1:0] CORDIC_GAIN = ROT_BITS'(652032874);
  localparam logic [0:0] KIND_PARTICLE = 1'b0;
  localparam logic [0:0] KIND_END      = 1'b1;

  typedef struct packed {
    logic [0:0]            kind;
    logic [EVENT_BITS-1:0] event_number;
    logic [ANGLE_BITS-1:0] angle;
  } in_word_t;

  typedef struct packed {
    logic [EVENT_BITS-1:0]      finished_event;
    logic [COUNT_BITS-1:0]      particle_count;
    logic signed [SUM_BITS-1:0] cos_sum;
    logic signed [SUM_BITS-1:0] sin_sum;
    logic [MAG_BITS-1:0]        q_magnitude;
  } out_word_t;

  typedef struct packed {
    logic [EVENT_BITS-1:0]      ev;
    logic [COUNT_BITS-1:0]      count;
    logic signed [SUM_BITS-1:0] cos_sum;
    logic signed [SUM_BITS-1:0] sin_sum;
  } snap_t;

  typedef enum logic [1:0] {F_IDLE, F_ROT, F_ACC} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_SQ, B_DIV, B_SQRT, B_OUT} back_state_t;

  function automatic logic signed [Z_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] i);
    logic signed [Z_BITS-1:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/efvm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module efvm_front (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_push,
  input  wire efvm_pkg::in_word_t                      in_data,
  output logic                                         in_full,
  input  wire logic                                    cfg_we,
  input  wire logic [efvm_pkg::HARM_BITS-1:0]          cfg_wdata,
  output logic                                         q_push,
  output efvm_pkg::snap_t                              q_data,
  input  wire logic                                    q_full
);

  efvm_pkg::front_state_t state_r, state_nxt;
  logic [efvm_pkg::HARM_BITS-1:0]           harm_r;
  logic [efvm_pkg::EVENT_BITS-1:0]          cur_ev_r;
  logic [efvm_pkg::COUNT_BITS-1:0]          count_r;
  logic signed [efvm_pkg::SUM_BITS-1:0]     cos_r, sin_r;
  logic [efvm_pkg::STEP_BITS-1:0]           step_r;
  logic signed [efvm_pkg::ROT_BITS-1:0]     x_r, y_r;
  logic signed [efvm_pkg::Z_BITS-1:0]       z_r;
  logic [1:0]                               quad_r;

  logic accept, new_event;
  logic [efvm_pkg::ANGLE_BITS+efvm_pkg::HARM_BITS-1:0] prod;
  logic [31:0] phase;
  logic signed [efvm_pkg::ROT_BITS-1:0] dx, dy;
  logic signed [efvm_pkg::TRIG_BITS-1:0] cr, sr, c_val, s_val;
  logic signed [efvm_pkg::SUM_BITS:0] cos_add, sin_add;

  function automatic logic signed [efvm_pkg::TRIG_BITS-1:0] to_trig(
      input logic signed [efvm_pkg::ROT_BITS-1:0] v);
    logic signed [efvm_pkg::ROT_BITS:0] t;
    logic signed [efvm_pkg::ROT_BITS:0] one;
    t = (efvm_pkg::ROT_BITS+1)'(v)
        + ((efvm_pkg::ROT_BITS+1)'(1) <<< (efvm_pkg::CORDIC_FRAC - efvm_pkg::TRIG_FRAC_BITS - 1));
    t = t >>> (efvm_pkg::CORDIC_FRAC - efvm_pkg::TRIG_FRAC_BITS);
    one = (efvm_pkg::ROT_BITS+1)'(1) <<< efvm_pkg::TRIG_FRAC_BITS;
    if (t > one) t = one;
    if (t < -one) t = -one;
    return t[efvm_pkg::TRIG_BITS-1:0];
  endfunction

  function automatic logic signed [efvm_pkg::SUM_BITS-1:0] sat_sum(
      input logic signed [efvm_pkg::SUM_BITS:0] v);
    logic signed [efvm_pkg::SUM_BITS-1:0] r;
    if (v[efvm_pkg::SUM_BITS] != v[efvm_pkg::SUM_BITS-1])
      r = v[efvm_pkg::SUM_BITS] ? {1'b1, {(efvm_pkg::SUM_BITS-1){1'b0}}}
                                : {1'b0, {(efvm_pkg::SUM_BITS-1){1'b1}}};
    else
      r = v[efvm_pkg::SUM_BITS-1:0];
    return r;
  endfunction

  assign accept    = in_push && !in_full;
  assign new_event = (in_data.kind == efvm_pkg::KIND_END) || (in_data.event_number != cur_ev_r);
  assign q_push    = accept && new_event && (count_r != '0);
  assign q_data    = '{ev: cur_ev_r, count: count_r, cos_sum: cos_r, sin_sum: sin_r};

  assign prod  = in_data.angle * harm_r;
  assign phase = {prod[efvm_pkg::ANGLE_BITS-1:0], {(32-efvm_pkg::ANGLE_BITS){1'b0}}};
  assign dx    = y_r >>> step_r;
  assign dy    = x_r >>> step_r;

  always_comb begin
    cr = to_trig(x_r);
    sr = to_trig(y_r);
    case (quad_r)
      2'd0:    begin c_val = cr;  s_val = sr;  end
      2'd1:    begin c_val = -sr; s_val = cr;  end
      2'd2:    begin c_val = -cr; s_val = -sr; end
      default: begin c_val = sr;  s_val = -cr; end
    endcase
    cos_add = (efvm_pkg::SUM_BITS+1)'(cos_r) + (efvm_pkg::SUM_BITS+1)'(c_val);
    sin_add = (efvm_pkg::SUM_BITS+1)'(sin_r) + (efvm_pkg::SUM_BITS+1)'(s_val);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efvm_pkg::F_IDLE:
        if (accept && in_data.kind == efvm_pkg::KIND_PARTICLE) state_nxt = efvm_pkg::F_ROT;
      efvm_pkg::F_ROT:
        if (step_r == efvm_pkg::STEP_BITS'(efvm_pkg::CORDIC_STEPS - 1))
          state_nxt = efvm_pkg::F_ACC;
      efvm_pkg::F_ACC: state_nxt = efvm_pkg::F_IDLE;
      default:         state_nxt = efvm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      efvm_pkg::F_IDLE: in_full = q_full;
      default:          in_full = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= efvm_pkg::F_IDLE;
      harm_r   <= efvm_pkg::HARM_RESET;
      cur_ev_r <= efvm_pkg::EVENT_RESET;
      count_r  <= '0;
      cos_r    <= '0;
      sin_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) harm_r <= cfg_wdata;
      if (accept && new_event) begin
        count_r <= '0;
        cos_r   <= '0;
        sin_r   <= '0;
      end
      if (accept && in_data.kind == efvm_pkg::KIND_PARTICLE) cur_ev_r <= in_data.event_number;
      if (state_r == efvm_pkg::F_ACC) begin
        if (count_r != {efvm_pkg::COUNT_BITS{1'b1}}) count_r <= count_r + 1'b1;
        cos_r <= sat_sum(cos_add);
        sin_r <= sat_sum(sin_add);
      end
    end
  end

  // Rotation datapath; one CORDIC micro-rotation per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      step_r <= '0;
      x_r    <= efvm_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= efvm_pkg::Z_BITS'({2'b00, phase[29:0]});
      quad_r <= phase[31:30];
    end else if (state_r == efvm_pkg::F_ROT) begin
      step_r <= step_r + 1'b1;
      if (!z_r[efvm_pkg::Z_BITS-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - efvm_pkg::atan_turn(step_r);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + efvm_pkg::atan_turn(step_r);
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/efvm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module efvm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire efvm_pkg::snap_t wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output efvm_pkg::snap_t      rd_data,
  output logic                 empty
);

  efvm_pkg::snap_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign full    = fill_r == 2'd2;
  assign empty   = fill_r == 2'd0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= !wr_ptr_r;
      if (rd_en) rd_ptr_r <= !rd_ptr_r;
      if (wr_en && !rd_en)      fill_r <= fill_r + 1'b1;
      else if (rd_en && !wr_en) fill_r <= fill_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hdl/efvm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module efvm_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire efvm_pkg::snap_t  q_data,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output efvm_pkg::out_word_t   out_data,
  output logic                  out_empty,
  input  wire logic             out_pop
);

  efvm_pkg::back_state_t state_r, state_nxt;
  efvm_pkg::snap_t                     snap_r;
  logic [efvm_pkg::CNT_BITS-1:0]       cnt_r;
  logic [2*efvm_pkg::HALF_BITS-1:0]    prod_r;
  logic [1:0]                          sh_r;
  logic [efvm_pkg::SQ_BITS-1:0]        acc_r;
  logic [efvm_pkg::NUM_BITS-1:0]       n_r;
  logic [efvm_pkg::COUNT_BITS-1:0]     rem_r;
  logic                                sat_r;
  logic [efvm_pkg::RAD_BITS-1:0]       v_r;
  logic [efvm_pkg::SREM_BITS-1:0]      srem_r;
  logic [efvm_pkg::MAG_BITS-1:0]       root_r;
  logic                                out_valid_r;
  efvm_pkg::out_word_t                 out_data_r;

  logic [efvm_pkg::SUM_BITS-1:0] ax, ay, opnd;
  logic [efvm_pkg::HALF_BITS-1:0] ma, mb;
  logic [efvm_pkg::SQ_BITS-1:0] addend, acc_sum;
  logic [efvm_pkg::COUNT_BITS:0] remw;
  logic div_ge;
  logic [efvm_pkg::NUM_BITS-1:0] n_nxt;
  logic [efvm_pkg::SREM_BITS+1:0] sremw, trial;
  logic sq_ge;
  logic sq_last, div_last, sqrt_last, out_free;

  assign ax   = snap_r.cos_sum[efvm_pkg::SUM_BITS-1] ? -snap_r.cos_sum : snap_r.cos_sum;
  assign ay   = snap_r.sin_sum[efvm_pkg::SUM_BITS-1] ? -snap_r.sin_sum : snap_r.sin_sum;
  assign opnd = (cnt_r < efvm_pkg::CNT_BITS'(3)) ? ax : ay;

  // Squares are built from three half-width partial products per operand.
  always_comb begin
    case (cnt_r)
      efvm_pkg::CNT_BITS'(0), efvm_pkg::CNT_BITS'(3): begin
        ma = opnd[efvm_pkg::HALF_BITS-1:0];
        mb = opnd[efvm_pkg::HALF_BITS-1:0];
      end
      efvm_pkg::CNT_BITS'(1), efvm_pkg::CNT_BITS'(4): begin
        ma = opnd[efvm_pkg::HALF_BITS-1:0];
        mb = opnd[2*efvm_pkg::HALF_BITS-1:efvm_pkg::HALF_BITS];
      end
      default: begin
        ma = opnd[2*efvm_pkg::HALF_BITS-1:efvm_pkg::HALF_BITS];
        mb = opnd[2*efvm_pkg::HALF_BITS-1:efvm_pkg::HALF_BITS];
      end
    endcase
    case (sh_r)
      2'd0:    addend = efvm_pkg::SQ_BITS'(prod_r);
      2'd1:    addend = efvm_pkg::SQ_BITS'(prod_r) << (efvm_pkg::HALF_BITS + 1);
      default: addend = efvm_pkg::SQ_BITS'(prod_r) << (2 * efvm_pkg::HALF_BITS);
    endcase
    acc_sum = acc_r + addend;
  end

  assign remw   = {rem_r, n_r[efvm_pkg::NUM_BITS-1]};
  assign div_ge = remw >= {1'b0, snap_r.count};
  assign n_nxt  = {n_r[efvm_pkg::NUM_BITS-2:0], div_ge};

  assign sremw = {srem_r, v_r[efvm_pkg::RAD_BITS-1:efvm_pkg::RAD_BITS-2]};
  assign trial = (efvm_pkg::SREM_BITS+2)'({root_r, 2'b01});
  assign sq_ge = sremw >= trial;

  assign sq_last   = cnt_r == efvm_pkg::CNT_BITS'(6);
  assign div_last  = cnt_r == efvm_pkg::CNT_BITS'(efvm_pkg::NUM_BITS - 1);
  assign sqrt_last = cnt_r == efvm_pkg::CNT_BITS'(efvm_pkg::MAG_BITS - 1);
  assign out_free  = !out_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efvm_pkg::B_IDLE: if (!q_empty)  state_nxt = efvm_pkg::B_SQ;
      efvm_pkg::B_SQ:   if (sq_last)   state_nxt = efvm_pkg::B_DIV;
      efvm_pkg::B_DIV:  if (div_last)  state_nxt = efvm_pkg::B_SQRT;
      efvm_pkg::B_SQRT: if (sqrt_last) state_nxt = efvm_pkg::B_OUT;
      efvm_pkg::B_OUT:  if (out_free)  state_nxt = efvm_pkg::B_IDLE;
      default:          state_nxt = efvm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      efvm_pkg::B_IDLE: q_pop = !q_empty;
      default:          q_pop = 1'b0;
    endcase
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= efvm_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == efvm_pkg::B_OUT) out_valid_r <= 1'b1;
      else if (out_pop)               out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      snap_r <= q_data;
      cnt_r  <= '0;
      acc_r  <= '0;
      sh_r   <= 2'd0;
      prod_r <= '0;
    end
    if (state_r == efvm_pkg::B_SQ) begin
      prod_r <= ma * mb;
      case (cnt_r)
        efvm_pkg::CNT_BITS'(0), efvm_pkg::CNT_BITS'(3): sh_r <= 2'd0;
        efvm_pkg::CNT_BITS'(1), efvm_pkg::CNT_BITS'(4): sh_r <= 2'd1;
        default:                                        sh_r <= 2'd2;
      endcase
      // The first cycle adds the zero product left by the load.
      acc_r <= acc_sum;
      cnt_r <= cnt_r + 1'b1;
      if (sq_last) begin
        n_r   <= {acc_sum, {efvm_pkg::NORM_SHIFT{1'b0}}};
        rem_r <= '0;
        cnt_r <= '0;
      end
    end
    if (state_r == efvm_pkg::B_DIV) begin
      rem_r <= div_ge ? efvm_pkg::COUNT_BITS'(remw - {1'b0, snap_r.count})
                      : remw[efvm_pkg::COUNT_BITS-1:0];
      n_r   <= n_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (div_last) begin
        sat_r  <= |n_nxt[efvm_pkg::NUM_BITS-1:efvm_pkg::RAD_BITS];
        v_r    <= n_nxt[efvm_pkg::RAD_BITS-1:0];
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
    end
    if (state_r == efvm_pkg::B_SQRT) begin
      srem_r <= sq_ge ? efvm_pkg::SREM_BITS'(sremw - trial) : efvm_pkg::SREM_BITS'(sremw);
      root_r <= {root_r[efvm_pkg::MAG_BITS-2:0], sq_ge};
      v_r    <= {v_r[efvm_pkg::RAD_BITS-3:0], 2'b00};
      cnt_r  <= cnt_r + 1'b1;
    end
    if (state_r == efvm_pkg::B_OUT && out_free) begin
      out_data_r.finished_event <= snap_r.ev;
      out_data_r.particle_count <= snap_r.count;
      out_data_r.cos_sum        <= snap_r.cos_sum;
      out_data_r.sin_sum        <= snap_r.sin_sum;
      out_data_r.q_magnitude    <= sat_r ? {efvm_pkg::MAG_BITS{1'b1}} : root_r;
    end
  end

endmodule
`default_nettype wire

/* hdl/event_flow_vector_magnitude.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flow-vector magnitude per event over a particle stream.
// Input queue side: drive in_data and raise in_push; the word is taken at a
// clock edge where in_full is low. A particle word whose event number differs
// from the current one, or an end word, closes the current event; an event with
// no particles reports nothing. Each particle word occupies the front while it
// is accepted, put through 28 serial CORDIC rotations and accumulated; in_full
// stays high meanwhile, so no new word is taken until the last is through.
// Result queue side: while out_empty is low out_data holds the oldest event
// result; raise out_pop to take it. A closed event goes through a two-entry
// queue to the back end, which works through partial-product squaring,
// bit-serial division, bit-serial square root and a write of the output
// register for each result. If results are not popped the back end and
// then the queue fill, and in_full stays high until there is room again.
// cfg_we/cfg_wdata load the harmonic order; write it only while idle.
// Synchronous reset clears the event state (current event 1, empty sums), sets
// the harmonic order to 2 and empties both queues.
module event_flow_vector_magnitude (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire efvm_pkg::in_word_t             in_data,
  output logic                                in_full,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output efvm_pkg::out_word_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [efvm_pkg::HARM_BITS-1:0] cfg_wdata
);

  logic            q_push, q_full, q_pop, q_empty;
  efvm_pkg::snap_t q_wdata, q_rdata;

  efvm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
  );

  efvm_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(q_push), .wr_data(q_wdata), .full(q_full),
    .rd_en(q_pop), .rd_data(q_rdata), .empty(q_empty)
  );

  efvm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_data(q_rdata), .q_empty(q_empty), .q_pop(q_pop),
    .out_data(out_data), .out_empty(out_empty), .out_pop(out_pop)
  );

endmodule
`default_nettype wire

/* hdl/efvm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module efvm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_push,
  input wire efvm_pkg::in_word_t             in_data,
  input wire logic                           in_full,
  input wire logic                           out_empty,
  input wire logic                           out_pop,
  input wire efvm_pkg::out_word_t            out_data
);

  // Reset leaves both sides empty and ready.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("block not empty after reset");

  // A reported event always holds at least one particle.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.particle_count != '0)
    else $error("result word with zero particle count");

  // A particle word keeps the front busy for the following cycle.
  a_busy_after_particle: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && in_data.kind == efvm_pkg::KIND_PARTICLE |=> in_full)
    else $error("front accepted back-to-back particle words");

  // A waiting result word holds until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("result word changed while waiting");

endmodule

bind event_flow_vector_magnitude efvm_checker u_efvm_checker (.*);
`default_nettype wire

/* tb/event_flow_vector_magnitude_tb.sv */
`timescale 1ns / 1ps
module event_flow_vector_magnitude_tb;

  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 600;
  localparam int SETTLE       = 250;
  localparam int PHASE_WORDS  = 110;

  class flow_scoreboard;
    efvm_pkg::out_word_t             expected_q[$];
    int                              errors;
    logic [efvm_pkg::HARM_BITS-1:0]  harm;
    logic [efvm_pkg::EVENT_BITS-1:0] cur_ev;
    logic [efvm_pkg::COUNT_BITS-1:0] cnt;
    longint                          sx, sy;
    longint                          atan_tab[28];

    function new();
      harm = efvm_pkg::HARM_RESET;
      cur_ev = efvm_pkg::EVENT_RESET;
      cnt = 0;
      sx = 0;
      sy = 0;
      errors = 0;
      atan_tab = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005};
    endfunction

    function longint round_trig(longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32768) r = 32768;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    function longint clamp_sum(longint v);
      longint hi;
      hi = (64'sd1 <<< (efvm_pkg::SUM_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void harmonic_trig(input logic [efvm_pkg::ANGLE_BITS-1:0] ang,
                                output longint c, output longint s);
      logic [efvm_pkg::ANGLE_BITS-1:0] ph;
      longint x, y, z, dx, dy, cr, sr;
      ph = efvm_pkg::ANGLE_BITS'(32'(ang) * 32'(harm));
      z = longint'({ph[13:0], 16'd0});
      x = 652032874;
      y = 0;
      for (int i = 0; i < 28; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      cr = round_trig(x);
      sr = round_trig(y);
      case (ph[15:14])
        2'd0: begin c = cr;  s = sr;  end
        2'd1: begin c = -sr; s = cr;  end
        2'd2: begin c = -cr; s = -sr; end
        default: begin c = sr; s = -cr; end
      endcase
    endfunction

    function logic [efvm_pkg::MAG_BITS-1:0] flow_magnitude();
      logic [127:0] ax, ay, num, quo;
      logic [63:0]  v, res, bitv;
      ax = (sx < 0) ? 128'(-sx) : 128'(sx);
      ay = (sy < 0) ? 128'(-sy) : 128'(sy);
      num = (ax * ax + ay * ay) << 2;
      quo = num / 128'(cnt);
      if (quo >= (128'd1 << (2 * efvm_pkg::MAG_BITS))) return '1;
      v = quo[63:0];
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return efvm_pkg::MAG_BITS'(res);
    endfunction

    function void close_event();
      efvm_pkg::out_word_t r;
      if (cnt != 0) begin
        r.finished_event = cur_ev;
        r.particle_count = cnt;
        r.cos_sum = efvm_pkg::SUM_BITS'(sx);
        r.sin_sum = efvm_pkg::SUM_BITS'(sy);
        r.q_magnitude = flow_magnitude();
        expected_q.insert(expected_q.size(), r);
      end
      cnt = 0;
      sx = 0;
      sy = 0;
    endfunction

    function void note_input(efvm_pkg::in_word_t w);
      longint c, s;
      if (w.kind == efvm_pkg::KIND_END) begin
        close_event();
        return;
      end
      if (w.event_number != cur_ev) begin
        close_event();
        cur_ev = w.event_number;
      end
      if (cnt != '1) cnt++;
      harmonic_trig(w.angle, c, s);
      sx = clamp_sum(sx + c);
      sy = clamp_sum(sy + s);
    endfunction

    function void check(efvm_pkg::out_word_t got);
      efvm_pkg::out_word_t exp_w;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %p", got);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.finished_event !== exp_w.finished_event ||
          got.particle_count !== exp_w.particle_count ||
          got.cos_sum !== exp_w.cos_sum || got.sin_sum !== exp_w.sin_sum ||
          got.q_magnitude !== exp_w.q_magnitude) begin
        errors++;
        if (errors <= 10)
          $display("result word differs: expected %p, got %p", exp_w, got);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_push = 1'b0;
  efvm_pkg::in_word_t             in_data = '0;
  logic                           in_full;
  logic                           out_empty;
  logic                           out_pop = 1'b0;
  efvm_pkg::out_word_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [efvm_pkg::HARM_BITS-1:0] cfg_wdata = '0;

  flow_scoreboard sb = new();
  bit  calm = 1'b0;
  bit  hold_long = 1'b0;
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  event_flow_vector_magnitude dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("event_flow_vector_magnitude: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) sb.check(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (hold_long) begin
        hold_long = 1'b0;
        hold_left = LONG_HOLD;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic send_word(efvm_pkg::in_word_t w);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_data <= w;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    sb.note_input(w);
  endtask

  task automatic send_particle(logic [efvm_pkg::EVENT_BITS-1:0] ev_no,
                               logic [efvm_pkg::ANGLE_BITS-1:0] ang);
    efvm_pkg::in_word_t w;
    w.kind = efvm_pkg::KIND_PARTICLE;
    w.event_number = ev_no;
    w.angle = ang;
    send_word(w);
  endtask

  task automatic send_end();
    efvm_pkg::in_word_t w;
    w.kind = efvm_pkg::KIND_END;
    w.event_number = $urandom;
    w.angle = efvm_pkg::ANGLE_BITS'($urandom);
    send_word(w);
  endtask

  // The block is idle once nothing is expected and the back end has drained.
  task automatic drain();
    in_push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_harmonic(logic [efvm_pkg::HARM_BITS-1:0] n);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.harm = n;
  endtask

  function automatic logic [efvm_pkg::ANGLE_BITS-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return efvm_pkg::ANGLE_BITS'($urandom_range(0, 3)) << 14;
      default: return efvm_pkg::ANGLE_BITS'($urandom);
    endcase
  endfunction

  task automatic random_events(int words);
    logic [efvm_pkg::EVENT_BITS-1:0] ev_no;
    int sent;
    int group;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 19) == 0) begin
        send_end();
        sent++;
      end else begin
        case ($urandom_range(0, 5))
          0: ev_no = sb.cur_ev;
          1: ev_no = '1;
          2: ev_no = efvm_pkg::EVENT_BITS'($urandom_range(0, 7));
          default: ev_no = $urandom;
        endcase
        group = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int k = 0; k < group; k++) send_particle(ev_no, pick_angle());
        sent += group;
      end
    end
    send_end();
  endtask

  initial begin
    logic [efvm_pkg::HARM_BITS-1:0] orders[7];
    orders = '{efvm_pkg::HARM_RESET, 4'd0, 4'd1, 4'd8, 4'd15, 4'd5, 4'd11};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset harmonic.
    send_end();
    send_particle(32'd1, 16'h0000);
    send_particle(32'd1, 16'hFFFF);
    send_particle(32'hFFFFFFFF, 16'h4000);
    send_particle(32'hFFFFFFFF, 16'h8000);
    send_particle(32'hFFFFFFFF, 16'hC000);
    send_particle(32'd0, 16'h2000);
    send_particle(32'd0, 16'h0001);
    send_end();
    send_end();
    // Same event number right after a flush continues as a fresh event.
    send_particle(32'd0, 16'h6000);
    send_particle(32'hA5A5A5A5, 16'h5A5A);
    send_particle(32'h5A5A5A5A, 16'hA5A5);
    for (int k = 0; k < 6; k++) send_particle(32'h5A5A5A5A, 16'h1234);
    send_end();
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p > 0) set_harmonic(orders[p]);
      if (p == 6) calm = 1'b1;
      if (p == 2) hold_long = 1'b1;
      random_events(PHASE_WORDS);
      drain();
    end
    set_harmonic(efvm_pkg::HARM_RESET);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("event_flow_vector_magnitude: match");
    end else begin
      $display("event_flow_vector_magnitude: mismatch");
    end
    $finish;
  end
endmodule
